// ===== rtl/dre_pkg.sv =====
// Shared types, constants and register codes of the distance ratio extremes block.
`default_nettype none
package dre_pkg;

	localparam int DEF_MAX_POINTS  = 64;
	localparam int DEF_MAX_DIMS    = 8;
	localparam int DEF_COORD_WIDTH = 16;

	localparam int RATIO_W = 48;
	localparam int ROOT_W  = 24;
	localparam int FRAC_W  = 16;

	// Widest point and coordinate index over the legal parameter range.
	localparam int PIDX_W = 10;
	localparam int KIDX_W = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FROM_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TO_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_DIMS   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_PAIR_INIT,
		ST_NUM,
		ST_DEN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_UPDATE,
		ST_SQ_MIN_GO,
		ST_SQ_MIN_WAIT,
		ST_SQ_MAX_GO,
		ST_SQ_MAX_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic              rd_space;
		logic              rd_set_b;
		logic [PIDX_W-1:0] rd_pa;
		logic [PIDX_W-1:0] rd_pb;
		logic [KIDX_W-1:0] rd_k;
		logic              acc_clr;
		logic              ext_clr;
		logic              div_start;
		logic              upd;
		logic              sqrt_start;
		logic              sqrt_sel;
		logic              emit_load;
		logic              no_pairs;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_done;
		logic sqrt_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/distance_ratio_extremes.sv =====
// Top level of the distance ratio extremes block.
// Coordinates are loaded one transfer per cycle into a store of 4*MAX_POINTS*MAX_DIMS
// entries, each count rounded up to a power of two, with no clearing pass: the user must
// write every coordinate the walk reads first; the block does not enforce it. The transfer
// marked tlast starts the pair walk, and the input stalls until that walk has finished and
// its result sits in the output register. Each pair reads num_dims + den_dims coordinate
// pairs through the squaring pipeline, then runs the bit-serial divider (DVD_W = 2*COORD_WIDTH
// + clog2(MAX_DIMS+1) + 16, 52 with the default parameters); after the last pair two 24-step
// square roots follow. The divider sets the walk's length for all but large dimension counts.
`default_nettype none
module distance_ratio_extremes #(
	parameter int MAX_POINTS  = dre_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIMS    = dre_pkg::DEF_MAX_DIMS,
	parameter int COORD_WIDTH = dre_pkg::DEF_COORD_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dre_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [31:0]                    s_tdata,  // point_index, coord_index, coord_value
	input  wire logic [1:0]                     s_tuser,  // set_select, space_select
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [47:0]                         m_tdata,  // min_root, max_root
	output logic [1:0]                          m_tuser   // saturated, no_pairs
);
	dre_pkg::dp_cmd_t  cmd;
	dre_pkg::dp_stat_t stat;
	logic [dre_pkg::ROOT_W-1:0] min_root;
	logic [dre_pkg::ROOT_W-1:0] max_root;
	logic saturated;
	logic no_pairs;

	dre_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_DIMS   (MAX_DIMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dre_dp #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_DIMS    (MAX_DIMS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (s_tvalid && s_tready),
		.wr_set    (s_tuser[0]),
		.wr_space  (s_tuser[1]),
		.wr_point  (s_tdata[5:0]),
		.wr_coord  (s_tdata[8:6]),
		.wr_value  ($signed(s_tdata[24:9])),
		.cmd       (cmd),
		.stat      (stat),
		.min_root  (min_root),
		.max_root  (max_root),
		.saturated (saturated),
		.no_pairs  (no_pairs)
	);

	assign m_tdata = {max_root, min_root};
	assign m_tuser = {no_pairs, saturated};
endmodule
`default_nettype wire

// ===== rtl/dre_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dre_div #(
	parameter int DVD_W = 56,
	parameter int DVS_W = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/dre_sqrt.sv =====
// Digit-by-digit floor square root, one root bit per cycle.
`default_nettype none
module dre_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dre_pkg::RATIO_W-1:0] radicand,
	output logic                             done,
	output logic [dre_pkg::ROOT_W-1:0]       root
);
	localparam int RW    = dre_pkg::ROOT_W;
	localparam int REM_W = RW + 3;
	localparam int CNT_W = $clog2(RW + 1);

	logic [dre_pkg::RATIO_W-1:0] val_q;
	logic [REM_W-1:0]            rem_q;
	logic [RW-1:0]               root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [REM_W-1:0]            rem_sh;
	logic [REM_W-1:0]            trial;
	logic                        fits;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], val_q[dre_pkg::RATIO_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== rtl/dre_dp.sv =====
// Datapath: coordinate store, squared distance pipeline, divider, extremes and roots.
`default_nettype none
module dre_dp #(
	parameter int MAX_POINTS  = dre_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIMS    = dre_pkg::DEF_MAX_DIMS,
	parameter int COORD_WIDTH = dre_pkg::DEF_COORD_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic                       wr_set,
	input  wire logic                       wr_space,
	input  wire logic [5:0]                 wr_point,
	input  wire logic [2:0]                 wr_coord,
	input  wire logic signed [15:0]         wr_value,
	input  wire dre_pkg::dp_cmd_t           cmd,
	output dre_pkg::dp_stat_t               stat,
	output logic [dre_pkg::ROOT_W-1:0]      min_root,
	output logic [dre_pkg::ROOT_W-1:0]      max_root,
	output logic                            saturated,
	output logic                            no_pairs
);
	localparam int CW     = COORD_WIDTH;
	localparam int PW     = $clog2(MAX_POINTS);
	localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW     = PW + DW + 2;
	localparam int DEPTH  = 1 << AW;
	localparam int SQ_W   = 2 * CW;
	localparam int SUM_W  = SQ_W + $clog2(MAX_DIMS + 1);
	localparam int DVD_W  = SUM_W + dre_pkg::FRAC_W;
	localparam int RW     = dre_pkg::RATIO_W;

	logic signed [CW-1:0] mem [DEPTH];

	logic [31:0]          pt32;
	logic [31:0]          k32;
	logic                 wr_ok;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr_a;
	logic [AW-1:0]        rd_addr_b;

	logic signed [CW-1:0] a_s1;
	logic signed [CW-1:0] b_s1;
	logic                 vld_s1, vld_s2, vld_s3;
	logic                 spc_s1, spc_s2, spc_s3;
	logic signed [CW:0]   diff_s2;
	logic [SQ_W-1:0]      sq_s3;
	logic signed [2*CW+1:0] prod;

	logic [SUM_W-1:0]     num_acc_q;
	logic [SUM_W-1:0]     den_acc_q;

	logic [DVD_W-1:0]     quo;
	logic                 div_done;
	logic                 den_zero;
	logic                 num_zero;
	logic                 q_big;
	logic [RW-1:0]        ratio;

	logic [RW-1:0]        min_q;
	logic [RW-1:0]        max_q;
	logic                 sat_q;

	logic                 sqrt_done;
	logic                 sqrt_sel_q;
	logic [dre_pkg::ROOT_W-1:0] root;
	logic [dre_pkg::ROOT_W-1:0] min_root_q;
	logic [dre_pkg::ROOT_W-1:0] max_root_q;

	logic [dre_pkg::ROOT_W-1:0] out_min_q;
	logic [dre_pkg::ROOT_W-1:0] out_max_q;
	logic                       out_sat_q;
	logic                       out_np_q;

	always_comb begin
		pt32      = 32'(wr_point);
		k32       = 32'(wr_coord);
		wr_ok     = (pt32 < MAX_POINTS) && (k32 < MAX_DIMS);
		wr_addr   = {wr_set, wr_space, pt32[PW-1:0], k32[DW-1:0]};
		rd_addr_a = {1'b0, cmd.rd_space, cmd.rd_pa[PW-1:0], cmd.rd_k[DW-1:0]};
		rd_addr_b = {cmd.rd_set_b, cmd.rd_space, cmd.rd_pb[PW-1:0], cmd.rd_k[DW-1:0]};
	end

	// Narrow coordinates wrap, wide ones sign-extend: the size cast does both.
	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem[wr_addr] <= CW'(wr_value);
		end
		a_s1 <= mem[rd_addr_a];
		b_s1 <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		prod = diff_s2 * diff_s2;
	end

	always_ff @(posedge clk) begin
		spc_s1  <= cmd.rd_space;
		spc_s2  <= spc_s1;
		spc_s3  <= spc_s2;
		diff_s2 <= (CW+1)'(a_s1) - (CW+1)'(b_s1);
		sq_s3   <= SQ_W'(prod);
		if (cmd.acc_clr) begin
			num_acc_q <= '0;
			den_acc_q <= '0;
		end else if (vld_s3) begin
			if (spc_s3) begin
				den_acc_q <= den_acc_q + SUM_W'(sq_s3);
			end else begin
				num_acc_q <= num_acc_q + SUM_W'(sq_s3);
			end
		end
	end

	dre_div #(
		.DVD_W (DVD_W),
		.DVS_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({num_acc_q, {dre_pkg::FRAC_W{1'b0}}}),
		.divisor  (den_acc_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		den_zero = den_acc_q == '0;
		num_zero = num_acc_q == '0;
		q_big    = (quo >> RW) != '0;
		ratio    = (den_zero || q_big) ? {RW{1'b1}} : RW'(quo);
	end

	always_ff @(posedge clk) begin
		if (cmd.ext_clr) begin
			min_q <= {RW{1'b1}};
			max_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.upd && !(den_zero && num_zero)) begin
			if (ratio < min_q) begin
				min_q <= ratio;
			end
			if (ratio > max_q) begin
				max_q <= ratio;
			end
			if (den_zero || q_big) begin
				sat_q <= 1'b1;
			end
		end
	end

	dre_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (cmd.sqrt_sel ? max_q : min_q),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sqrt_sel_q <= cmd.sqrt_sel;
		end
		if (sqrt_done) begin
			if (sqrt_sel_q) begin
				max_root_q <= root;
			end else begin
				min_root_q <= root;
			end
		end
		if (cmd.emit_load) begin
			out_min_q <= min_root_q;
			out_max_q <= max_root_q;
			out_sat_q <= sat_q;
			out_np_q  <= cmd.no_pairs;
		end
	end

	always_comb begin
		stat.pipe_busy = vld_s1 | vld_s2 | vld_s3;
		stat.div_done  = div_done;
		stat.sqrt_done = sqrt_done;
	end

	assign min_root  = out_min_q;
	assign max_root  = out_max_q;
	assign saturated = out_sat_q;
	assign no_pairs  = out_np_q;
endmodule
`default_nettype wire

// ===== rtl/dre_ctrl.sv =====
// Controller: configuration registers, load handshake and the pair walk sequencer.
`default_nettype none
module dre_ctrl #(
	parameter int MAX_POINTS = dre_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIMS   = dre_pkg::DEF_MAX_DIMS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dre_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dre_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              in_valid,
	input  wire logic                              in_last,
	output logic                                   in_ready,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output dre_pkg::dp_cmd_t                       cmd,
	input  wire dre_pkg::dp_stat_t                 stat
);
	localparam int CNT_W = $clog2(MAX_POINTS + 2) + 1;
	localparam int KC_W  = $clog2(MAX_DIMS + 1);

	dre_pkg::state_t state_q, state_d;

	logic             mode_q;
	logic [6:0]       from_count_q;
	logic [6:0]       to_count_q;
	logic [3:0]       num_dims_q;
	logic [3:0]       den_dims_q;

	logic [CNT_W-1:0] nf, nt;
	logic [KC_W-1:0]  nd, dd;
	logic [CNT_W-1:0] i_q, j_q;
	logic [KC_W-1:0]  k_q;
	logic [KC_W-1:0]  k_inc;
	logic             no_pairs_q;
	logic             out_valid_q;
	logic             any_pair;
	logic             row_end;
	logic             last_pair;
	logic             emit_ok;

	always_comb begin
		nf = (32'(from_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(from_count_q);
		nt = (32'(to_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(to_count_q);
		nd = (32'(num_dims_q) > MAX_DIMS) ? KC_W'(MAX_DIMS) : KC_W'(num_dims_q);
		dd = (32'(den_dims_q) > MAX_DIMS) ? KC_W'(MAX_DIMS) : KC_W'(den_dims_q);
		k_inc = k_q + 1'b1;
		any_pair = mode_q ? (nf != '0 && nt != '0) : (nf > CNT_W'(1));
		row_end  = mode_q ? (j_q + 1'b1 >= nt) : (j_q + 1'b1 >= nf);
		last_pair = mode_q ? (row_end && (i_q + 1'b1 >= nf))
		                   : (row_end && (i_q + CNT_W'(2) >= nf));
		emit_ok  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			from_count_q <= '0;
			to_count_q   <= '0;
			num_dims_q   <= 4'd1;
			den_dims_q   <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dre_pkg::REG_MODE:       mode_q       <= cfg_wdata[0];
				dre_pkg::REG_FROM_COUNT: from_count_q <= cfg_wdata;
				dre_pkg::REG_TO_COUNT:   to_count_q   <= cfg_wdata;
				dre_pkg::REG_NUM_DIMS:   num_dims_q   <= cfg_wdata[3:0];
				dre_pkg::REG_DEN_DIMS:   den_dims_q   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dre_pkg::ST_IDLE: begin
				if (in_valid && in_last) state_d = dre_pkg::ST_START;
			end
			dre_pkg::ST_START: begin
				state_d = any_pair ? dre_pkg::ST_PAIR_INIT : dre_pkg::ST_SQ_MIN_GO;
			end
			dre_pkg::ST_PAIR_INIT: begin
				if (nd != '0) state_d = dre_pkg::ST_NUM;
				else if (dd != '0) state_d = dre_pkg::ST_DEN;
				else state_d = dre_pkg::ST_DRAIN;
			end
			dre_pkg::ST_NUM: begin
				if (k_inc == nd) state_d = (dd != '0) ? dre_pkg::ST_DEN : dre_pkg::ST_DRAIN;
			end
			dre_pkg::ST_DEN: begin
				if (k_inc == dd) state_d = dre_pkg::ST_DRAIN;
			end
			dre_pkg::ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = dre_pkg::ST_DIV_GO;
			end
			dre_pkg::ST_DIV_GO:   state_d = dre_pkg::ST_DIV_WAIT;
			dre_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) state_d = dre_pkg::ST_UPDATE;
			end
			dre_pkg::ST_UPDATE: begin
				state_d = last_pair ? dre_pkg::ST_SQ_MIN_GO : dre_pkg::ST_PAIR_INIT;
			end
			dre_pkg::ST_SQ_MIN_GO:   state_d = dre_pkg::ST_SQ_MIN_WAIT;
			dre_pkg::ST_SQ_MIN_WAIT: begin
				if (stat.sqrt_done) state_d = dre_pkg::ST_SQ_MAX_GO;
			end
			dre_pkg::ST_SQ_MAX_GO:   state_d = dre_pkg::ST_SQ_MAX_WAIT;
			dre_pkg::ST_SQ_MAX_WAIT: begin
				if (stat.sqrt_done) state_d = dre_pkg::ST_EMIT;
			end
			dre_pkg::ST_EMIT: begin
				if (emit_ok) state_d = dre_pkg::ST_IDLE;
			end
			default: state_d = dre_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = state_q == dre_pkg::ST_IDLE;
		cmd            = '0;
		cmd.rd_en      = (state_q == dre_pkg::ST_NUM) || (state_q == dre_pkg::ST_DEN);
		cmd.rd_space   = state_q == dre_pkg::ST_DEN;
		cmd.rd_set_b   = mode_q;
		cmd.rd_pa      = dre_pkg::PIDX_W'(i_q);
		cmd.rd_pb      = dre_pkg::PIDX_W'(j_q);
		cmd.rd_k       = dre_pkg::KIDX_W'(k_q);
		cmd.acc_clr    = state_q == dre_pkg::ST_PAIR_INIT;
		cmd.ext_clr    = state_q == dre_pkg::ST_START;
		cmd.div_start  = state_q == dre_pkg::ST_DIV_GO;
		cmd.upd        = state_q == dre_pkg::ST_UPDATE;
		cmd.sqrt_start = (state_q == dre_pkg::ST_SQ_MIN_GO) ||
		                 (state_q == dre_pkg::ST_SQ_MAX_GO);
		cmd.sqrt_sel   = state_q == dre_pkg::ST_SQ_MAX_GO;
		cmd.emit_load  = (state_q == dre_pkg::ST_EMIT) && emit_ok;
		cmd.no_pairs   = no_pairs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dre_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			no_pairs_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dre_pkg::ST_START: begin
					i_q        <= '0;
					j_q        <= mode_q ? '0 : CNT_W'(1);
					no_pairs_q <= !any_pair;
				end
				dre_pkg::ST_PAIR_INIT: k_q <= '0;
				dre_pkg::ST_NUM:       k_q <= (k_inc == nd) ? '0 : k_inc;
				dre_pkg::ST_DEN:       k_q <= k_inc;
				dre_pkg::ST_UPDATE: begin
					if (!row_end) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= mode_q ? '0 : i_q + CNT_W'(2);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== rtl/dre_checker.sv =====
// Port-level checker for the distance ratio extremes block, with its bind.
`default_nettype none
module dre_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during pair walk");

	a_no_pairs_roots: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[23:0] == 24'hFFFFFF && m_tdata[47:24] == 24'd0
		&& !m_tuser[0])
		else $error("empty walk reported wrong roots");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[23:0] <= m_tdata[47:24]) ||
		(m_tdata[23:0] == 24'hFFFFFF && m_tdata[47:24] == 24'd0))
		else $error("minimum root above maximum root");
endmodule

bind distance_ratio_extremes dre_checker u_dre_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/distance_ratio_extremes_tb.sv =====
// Self-checking testbench for the distance ratio extremes block, with a scoreboard class.
`timescale 1ns / 1ps
module distance_ratio_extremes_tb;

	localparam longint unsigned RATIO_ONES = (64'd1 << 48) - 64'd1;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [23:0] min_root;
		logic [23:0] max_root;
		logic        saturated;
		logic        no_pairs;
	} extremes_t;

	class ratio_scoreboard;
		logic signed [15:0] coords [0:1][0:1][0:63][0:7];
		logic       mode;
		logic [6:0] from_count;
		logic [6:0] to_count;
		logic [3:0] num_dims;
		logic [3:0] den_dims;
		extremes_t  pending[$];
		int         errors;

		function new();
			mode = 1'b0;
			from_count = '0;
			to_count = '0;
			num_dims = 4'd1;
			den_dims = 4'd1;
			errors = 0;
		endfunction

		function void write_reg(logic [dre_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
			case (idx)
				dre_pkg::REG_MODE:       mode = val[0];
				dre_pkg::REG_FROM_COUNT: from_count = val;
				dre_pkg::REG_TO_COUNT:   to_count = val;
				dre_pkg::REG_NUM_DIMS:   num_dims = val[3:0];
				dre_pkg::REG_DEN_DIMS:   den_dims = val[3:0];
				default: ;
			endcase
		endfunction

		function longint unsigned sq_distance(int space, int sa, int pa, int sb, int pb, int dims);
			longint unsigned total;
			longint d;
			total = 0;
			for (int k = 0; k < dims; k++) begin
				d = longint'(coords[sa][space][pa][k]) - longint'(coords[sb][space][pb][k]);
				total += longint'(d * d);
			end
			return total;
		endfunction

		function logic [23:0] floor_root(longint unsigned v);
			longint unsigned r, t;
			r = 0;
			for (int b = 23; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r[23:0];
		endfunction

		// Stores the coordinate and, on the closing transfer, predicts the result.
		function void note_transfer(logic set_sel, logic space_sel, logic [5:0] pt, logic [2:0] k,
				logic signed [15:0] val, logic last);
			int nf, nt, nd, dd, j0, sb;
			longint unsigned lo, hi, num, den, q;
			logic sat, any;
			extremes_t e;
			coords[set_sel][space_sel][pt][k] = val;
			if (!last)
				return;
			nf = (from_count > 64) ? 64 : from_count;
			nt = (to_count > 64) ? 64 : to_count;
			nd = (num_dims > 8) ? 8 : num_dims;
			dd = (den_dims > 8) ? 8 : den_dims;
			lo = RATIO_ONES;
			hi = 0;
			sat = 0;
			any = 0;
			sb = mode ? 1 : 0;
			for (int i = 0; i < nf; i++) begin
				j0 = mode ? 0 : i + 1;
				for (int j = j0; j < (mode ? nt : nf); j++) begin
					any = 1;
					num = sq_distance(0, 0, i, sb, j, nd);
					den = sq_distance(1, 0, i, sb, j, dd);
					if (den == 0) begin
						if (num == 0)
							continue;
						q = RATIO_ONES;
						sat = 1;
					end else begin
						q = (num << 16) / den;
						if (q > RATIO_ONES) begin
							q = RATIO_ONES;
							sat = 1;
						end
					end
					if (q < lo)
						lo = q;
					if (q > hi)
						hi = q;
				end
			end
			e.min_root = floor_root(lo);
			e.max_root = floor_root(hi);
			e.saturated = sat;
			e.no_pairs = !any;
			pending.push_back(e);
		endfunction

		function void check_result(extremes_t got);
			extremes_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.min_root !== want.min_root) begin
				$display("%0t: min_root expected %h actual %h", $time, want.min_root, got.min_root);
				errors++;
			end
			if (got.max_root !== want.max_root) begin
				$display("%0t: max_root expected %h actual %h", $time, want.max_root, got.max_root);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time, want.saturated,
					got.saturated);
				errors++;
			end
			if (got.no_pairs !== want.no_pairs) begin
				$display("%0t: no_pairs expected %b actual %b", $time, want.no_pairs, got.no_pairs);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [dre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dre_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata = '0;   // point_index, coord_index, coord_value
	logic [1:0]                     s_tuser = '0;   // set_select, space_select
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [47:0]                    m_tdata;        // min_root, max_root
	logic [1:0]                     m_tuser;        // saturated, no_pairs

	ratio_scoreboard sb = new();
	int  cycles = 0;
	int  sent = 0;
	bit  quiet = 0;     // no idling on either side while set
	int  value_style = 0;

	distance_ratio_extremes uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tdata[23:0], m_tdata[47:24], m_tuser[0], m_tuser[1]});

	always @(negedge clk)
		m_tready = quiet || ($urandom_range(99) >= 7);

	function logic signed [15:0] pick_value();
		case (value_style)
			1: return ($urandom_range(1) != 0) ? 16'sd256 : 16'sd0;
			2: case ($urandom_range(2))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				default: return 16'sd0;
			endcase
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_transfer(logic set_sel, logic space_sel, logic [5:0] pt, logic [2:0] k,
			logic signed [15:0] val, logic last);
		while (!quiet && $urandom_range(99) < 7) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, val, k, pt};
		s_tuser = {space_sel, set_sel};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		sb.note_transfer(set_sel, space_sel, pt, k, val, last);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [dre_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_transfer(logic last);
		send_transfer(1'($urandom_range(1)), 1'($urandom_range(1)), 6'($urandom_range(63)),
			3'($urandom_range(7)), pick_value(), last);
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	// One computation: set the registers, load every coordinate the walk reads, then close.
	task automatic run_walk(logic mode, int nf, int nt, int nd, int dd, int noise);
		int nfe, nte, nde, dde, n, tmp;
		int loads[$];
		s_tvalid = 1'b0;
		wait_idle();
		repeat (10) @(negedge clk);
		write_reg(dre_pkg::REG_MODE, 7'(mode));
		write_reg(dre_pkg::REG_FROM_COUNT, 7'(nf));
		write_reg(dre_pkg::REG_TO_COUNT, 7'(nt));
		write_reg(dre_pkg::REG_NUM_DIMS, 7'(nd));
		write_reg(dre_pkg::REG_DEN_DIMS, 7'(dd));
		nfe = (nf > 64) ? 64 : nf;
		nte = mode ? ((nt > 64) ? 64 : nt) : 0;
		nde = (nd > 8) ? 8 : nd;
		dde = (dd > 8) ? 8 : dd;
		// Entry code: set, space, point, coordinate.
		for (int s = 0; s < 2; s++)
			for (int p = 0; p < (s ? nte : nfe); p++) begin
				for (int k = 0; k < nde; k++)
					loads.push_back((s << 10) | (p << 3) | k);
				for (int k = 0; k < dde; k++)
					loads.push_back((s << 10) | (1 << 9) | (p << 3) | k);
			end
		n = loads.size();
		for (int i = n - 1; i > 0; i--) begin
			tmp = $urandom_range(i);
			{loads[i], loads[tmp]} = {loads[tmp], loads[i]};
		end
		foreach (loads[i]) begin
			if ($urandom_range(99) < noise)
				random_transfer(1'b0);
			send_transfer(loads[i][10], loads[i][9], loads[i][8:3], loads[i][2:0],
				pick_value(), 1'b0);
		end
		random_transfer(1'b1);
	endtask

	initial begin
		int m;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration: from-set empty, so no pairs.
		random_transfer(1'b1);
		value_style = 2;
		run_walk(1'b0, 1, 0, 1, 1, 0);
		run_walk(1'b1, 2, 0, 1, 1, 0);
		run_walk(1'b0, 3, 0, 8, 8, 0);
		value_style = 1;
		run_walk(1'b1, 2, 2, 0, 2, 0);
		run_walk(1'b0, 3, 0, 15, 0, 0);

		value_style = 0;
		quiet = 1;
		run_walk(1'b0, 100, 0, 1, 1, 0);
		run_walk(1'b1, 2, 64, 1, 2, 0);
		for (int ph = 0; sent < 1100; ph++) begin
			quiet = (ph >= 10 && ph < 18);
			value_style = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2);
			m = $urandom_range(1);
			run_walk(1'(m), m ? $urandom_range(5) : $urandom_range(7), $urandom_range(5),
				($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
				($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
				10);
		end
		quiet = 0;
		s_tvalid = 1'b0;
		wait_idle();
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
